// ===== src/pcm_voice_register_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// PCM voice register encoder - assertion macros
// Shared shorthand for the concurrent checks in the encoder modules.
// ----------------------------------------------------------------------------
`ifndef PCM_VOICE_REGISTER_ENCODER_ASSERT_SVH
`define PCM_VOICE_REGISTER_ENCODER_ASSERT_SVH

// cond must hold at every edge out of reset
`define PVE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pve: invariant violated");

// same-cycle implication
`define PVE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pve: implication violated");

// next-cycle implication
`define PVE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pve: next-cycle implication violated");

`endif

// ===== src/pve_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM voice register encoder - package
// Word types, control structs, sequencer states and field mapping helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pve_pkg;

    localparam logic [22:0] BASE_RATE     = 23'd5644800;
    localparam logic [22:0] MIN_BASE      = 23'd172;
    localparam logic [3:0]  OCT_START     = 4'd7;
    localparam logic [3:0]  OCT_FLOOR     = 4'b1000;
    localparam int          MANT_W        = 10;
    localparam int          DIV_STEPS     = 32;
    localparam int          CNT_W         = $clog2(DIV_STEPS);
    localparam logic [7:0]  FILTER_OFF    = 8'h24;
    localparam logic [7:0]  PAN_CENTRE    = 8'h80;
    localparam logic [7:0]  PAN_CENTRE_LO = 8'h7f;
    localparam logic [3:0]  SEND_RESET    = 4'hf;

    typedef struct packed {
        logic               op;
        logic [5:0]         channel;
        logic [20:0]        sample_addr;
        logic [1:0]         sample_format;
        logic               loop_enable;
        logic [15:0]        loop_begin;
        logic [15:0]        frame_count;
        logic [21:0]        pitch_hz;
        logic signed [15:0] volume;
        logic [7:0]         pan;
    } pve_in_t;

    typedef struct packed {
        logic [5:0]  voice_channel;
        logic [15:0] play_word;
        logic [15:0] start_low_word;
        logic [15:0] loop_begin_word;
        logic [15:0] loop_end_word;
        logic [14:0] pitch_word;
        logic [11:0] pan_send_word;
        logic [15:0] level_filter_word;
    } pve_out_t;

    typedef enum logic [1:0] {
        PVE_IDLE,
        PVE_NORM,
        PVE_DIV,
        PVE_HOLD
    } pve_state_t;

    // sequencer -> pitch datapath
    typedef struct packed {
        logic load;
        logic norm_step;
        logic div_step;
        logic sel_div;
        logic finish;
    } pve_ctrl_t;

    // pitch datapath -> sequencer
    typedef struct packed {
        logic hz_lt_base;
        logic oct_floor;
        logic div_last;
    } pve_stat_t;

    localparam logic [7:0] ATTEN_TABLE [256] = '{
        8'd255, 8'd127, 8'd111, 8'd102, 8'd95, 8'd90, 8'd86, 8'd82,
        8'd79, 8'd77, 8'd74, 8'd72, 8'd70, 8'd68, 8'd66, 8'd65,
        8'd63, 8'd62, 8'd61, 8'd59, 8'd58, 8'd57, 8'd56, 8'd55,
        8'd54, 8'd53, 8'd52, 8'd51, 8'd50, 8'd50, 8'd49, 8'd48,
        8'd47, 8'd47, 8'd46, 8'd45, 8'd45, 8'd44, 8'd43, 8'd43,
        8'd42, 8'd42, 8'd41, 8'd41, 8'd40, 8'd40, 8'd39, 8'd39,
        8'd38, 8'd38, 8'd37, 8'd37, 8'd36, 8'd36, 8'd35, 8'd35,
        8'd34, 8'd34, 8'd34, 8'd33, 8'd33, 8'd33, 8'd32, 8'd32,
        8'd31, 8'd31, 8'd31, 8'd30, 8'd30, 8'd30, 8'd29, 8'd29,
        8'd29, 8'd28, 8'd28, 8'd28, 8'd27, 8'd27, 8'd27, 8'd27,
        8'd26, 8'd26, 8'd26, 8'd25, 8'd25, 8'd25, 8'd25, 8'd24,
        8'd24, 8'd24, 8'd24, 8'd23, 8'd23, 8'd23, 8'd23, 8'd22,
        8'd22, 8'd22, 8'd22, 8'd21, 8'd21, 8'd21, 8'd21, 8'd20,
        8'd20, 8'd20, 8'd20, 8'd20, 8'd19, 8'd19, 8'd19, 8'd19,
        8'd18, 8'd18, 8'd18, 8'd18, 8'd18, 8'd17, 8'd17, 8'd17,
        8'd17, 8'd17, 8'd17, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
        8'd15, 8'd15, 8'd15, 8'd15, 8'd15, 8'd15, 8'd14, 8'd14,
        8'd14, 8'd14, 8'd14, 8'd14, 8'd13, 8'd13, 8'd13, 8'd13,
        8'd13, 8'd13, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12,
        8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd10,
        8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd9, 8'd9,
        8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd8, 8'd8, 8'd8,
        8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd7, 8'd7, 8'd7,
        8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd6, 8'd6, 8'd6,
        8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd5, 8'd5, 8'd5,
        8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd4, 8'd4,
        8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd3,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
        8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    function automatic logic [7:0] clamp_volume(input logic signed [15:0] v);
        logic [7:0] r;
        if (v[15])
            r = 8'd0;
        else if (|v[14:8])
            r = 8'hff;
        else
            r = v[7:0];
        return r;
    endfunction

    // side bit 4, magnitude 3:0; centre gives zero
    function automatic logic [4:0] encode_pan(input logic [7:0] p);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'd0;
        if (p == PAN_CENTRE)
            r = 5'd0;
        else if (p < PAN_CENTRE)
        begin
            d = PAN_CENTRE_LO - p;
            r = {1'b1, d[6:3]};
        end
        else
        begin
            d = p - PAN_CENTRE;
            r = {1'b0, d[6:3]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/pcm_voice_register_encoder.sv =====
// ----------------------------------------------------------------------------
// PCM voice register encoder - top level
// Note-on request in, one set of voice register words out.
// ----------------------------------------------------------------------------
// One request is taken at a time. After the accepting edge the sequencer runs
// k octave halvings (1 to 15, more for lower pitches), one step to close the
// search, 32 restoring-divide steps and a hand-off, which stretches for as
// long as the output register is full and not being read. result_valid rises
// once the hand-off is registered, and item_ready returns the cycle after the
// hand-off. The search and the divide run one after the other through the
// single shared subtractor in the pitch datapath. The result sits in an
// output register, so the next request is taken while it waits.
// The send level is sampled at hand-off, so write it through cfg only while
// no request is in flight; it resets to 15.
`default_nettype none

`include "pcm_voice_register_encoder_assert.svh"

module pcm_voice_register_encoder
    import pve_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire pve_in_t    item,
    output logic            result_valid,
    input  wire logic       result_ready,
    output pve_out_t        result
);

    logic [3:0] level_reg, level_next;
    pve_in_t    hold_reg, hold_next;
    pve_out_t   result_reg, result_next;
    logic       valid_reg, valid_next;

    pve_ctrl_t   ctrl;
    pve_stat_t   stat;
    logic        idle;
    logic        slot_free;
    logic [14:0] pitch_word;
    logic [7:0]  vol8;

    assign cfg_ready    = 1'b1;
    assign item_ready   = idle;
    assign slot_free    = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    pve_pitch_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .slot_free  (slot_free),
        .stat       (stat),
        .ctrl       (ctrl),
        .idle       (idle)
    );

    pve_pitch_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pitch_hz   (item.pitch_hz),
        .stat       (stat),
        .pitch_word (pitch_word)
    );

    always_comb
    begin
        level_next = (cfg_valid && cfg_ready) ? cfg_data : level_reg;
        hold_next  = ctrl.load ? item : hold_reg;
        vol8       = clamp_volume(hold_reg.volume);

        result_next                   = result_reg;
        valid_next                    = valid_reg && !result_ready;
        if (ctrl.finish)
        begin
            result_next.voice_channel     = hold_reg.channel;
            result_next.play_word         = {~hold_reg.op, 1'b1, 4'd0, hold_reg.loop_enable,
                                             hold_reg.sample_format, 2'd0,
                                             hold_reg.sample_addr[20:16]};
            result_next.start_low_word    = hold_reg.sample_addr[15:0];
            result_next.loop_begin_word   = hold_reg.loop_begin;
            result_next.loop_end_word     = hold_reg.frame_count;
            result_next.pitch_word        = pitch_word;
            result_next.pan_send_word     = {level_reg, 3'd0, encode_pan(hold_reg.pan)};
            result_next.level_filter_word = {ATTEN_TABLE[vol8], FILTER_OFF};
            valid_next                    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= SEND_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        result_reg <= result_next;
    end

    `PVE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && item_ready, !item_ready)
    `PVE_ASSERT_IMPL(a_no_overwrite, clk, rst_n, ctrl.finish, !valid_reg || result_ready)

endmodule

`default_nettype wire

// ===== src/pve_pitch_dp.sv =====
// ----------------------------------------------------------------------------
// PVE pitch datapath
// Octave search and restoring divide, both through one shared subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcm_voice_register_encoder_assert.svh"

module pve_pitch_dp
    import pve_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pve_ctrl_t   ctrl,
    input  wire logic [21:0] pitch_hz,
    output pve_stat_t        stat,
    output logic [14:0]      pitch_word
);

    logic [21:0]       hz_reg,   hz_next;
    logic [22:0]       base_reg, base_next;
    logic [3:0]        oct_reg,  oct_next;
    logic [22:0]       rem_reg,  rem_next;
    logic [31:0]       dvd_reg,  dvd_next;
    logic [MANT_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;

    logic [23:0] sub_a;
    logic [24:0] diff;
    logic        borrow;

    // shared unit: hz vs base while searching, partial remainder vs base while dividing
    always_comb
    begin
        sub_a  = ctrl.sel_div ? {rem_reg, dvd_reg[31]} : {2'b00, hz_reg};
        diff   = {1'b0, sub_a} - {2'b00, base_reg};
        borrow = diff[24];
    end

    always_comb
    begin
        hz_next   = hz_reg;
        base_next = base_reg;
        oct_next  = oct_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        if (ctrl.load)
        begin
            hz_next   = pitch_hz;
            base_next = BASE_RATE;
            oct_next  = OCT_START;
            rem_next  = '0;
            dvd_next  = {pitch_hz, 10'd0};
            cnt_next  = '0;
        end
        else if (ctrl.norm_step)
        begin
            base_next = base_reg >> 1;
            oct_next  = oct_reg - 4'd1;
        end
        else if (ctrl.div_step)
        begin
            rem_next = borrow ? sub_a[22:0] : diff[22:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            quo_next = {quo_reg[MANT_W-2:0], ~borrow};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hz_reg   <= hz_next;
        base_reg <= base_next;
        oct_reg  <= oct_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
    end

    always_comb
    begin
        stat.hz_lt_base = borrow;
        stat.oct_floor  = (oct_reg == OCT_FLOOR);
        stat.div_last   = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        pitch_word      = {oct_reg, 1'b0, quo_reg};
    end

    `PVE_ASSERT_IMPL(a_rem_below_base, clk, rst_n, ctrl.sel_div, rem_reg < base_reg)
    `PVE_ASSERT_IMPL(a_base_floor, clk, rst_n, ctrl.sel_div, base_reg >= MIN_BASE)

endmodule

`default_nettype wire

// ===== src/pve_pitch_seq.sv =====
// ----------------------------------------------------------------------------
// PVE pitch sequencer
// Steps the octave search, then the divide, then hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pve_pitch_seq
    import pve_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire logic      slot_free,
    input  wire pve_stat_t stat,
    output pve_ctrl_t      ctrl,
    output logic           idle
);

    pve_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PVE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        idle       = 1'b0;
        unique case (state_reg)
            PVE_IDLE:
            begin
                idle = 1'b1;
                if (item_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = PVE_NORM;
                end
            end
            PVE_NORM:
            begin
                if (stat.hz_lt_base && !stat.oct_floor)
                    ctrl.norm_step = 1'b1;
                else
                    state_next = PVE_DIV;
            end
            PVE_DIV:
            begin
                ctrl.sel_div  = 1'b1;
                ctrl.div_step = 1'b1;
                if (stat.div_last)
                    state_next = PVE_HOLD;
            end
            PVE_HOLD:
            begin
                if (slot_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = PVE_IDLE;
                end
            end
            default:
            begin
                state_next = PVE_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
